FILE: rtl/pccc_pkg.sv
// ============================================================================
// pccc_pkg
// shared types and constants for the charge pump current code calculator
// ============================================================================
`default_nettype none

package pccc_pkg;

    // line frequency numerator and current estimate gain constant
    localparam int unsigned LINE_W      = 15;
    localparam int unsigned GAIN_CONST_W = 26;
    localparam logic [LINE_W-1:0]       LINE_CONST = 15'd24576;
    localparam logic [GAIN_CONST_W-1:0] GAIN_CONST = 26'd50737400;

    // divider widths: the dividend holds gain * GAIN_CONST at full precision
    localparam int unsigned DVD_W     = 34;
    localparam int unsigned DVS_W     = 16;
    localparam int unsigned DIV_CNT_W = 4;

    // the estimate is quotient bits 27:20, so the second pass stops at bit 20
    localparam int unsigned EST_SHIFT = 20;

    // iteration counts minus one for the two divider passes
    localparam logic [DIV_CNT_W-1:0] DIV1_LAST_CNT = 4'(LINE_W - 1);
    localparam logic [DIV_CNT_W-1:0] DIV2_LAST_CNT = 4'(DVD_W - EST_SHIFT - 1);

    localparam logic [4:0] START_CODE    = 5'd14;
    localparam logic [7:0] TARGET_OFFSET = 8'd10;

    // configuration register indexes
    localparam logic [7:0] CFG_FIXED_CORR  = 8'd0;
    localparam logic [7:0] CFG_CORR_TOTAL  = 8'd1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_ZERO_EST = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV1,
        S_DIV2,
        S_NORM,
        S_OUT
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] last_cnt;
    } div_req_t;

    typedef struct packed {
        logic       start;
        logic [7:0] est;
    } norm_req_t;

    typedef struct packed {
        logic       done;
        logic [4:0] code;
        logic       half;
    } norm_res_t;

endpackage

`default_nettype wire

FILE: rtl/pccc_div.sv
// ============================================================================
// pccc_div
// restoring divider, one quotient bit per cycle, msb first
// ============================================================================
`default_nettype none

module pccc_div
    import pccc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire div_req_t         req,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic [DVD_W-1:0]      quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0]     dvd_reg, dvd_next;
    logic [DVS_W-1:0]     dvs_reg, dvs_next;
    logic [DVS_W-1:0]     rem_reg, rem_next;
    logic [DVD_W-1:0]     quo_reg, quo_next;

    logic [DVS_W:0] trial;
    logic [DVS_W:0] diff;
    logic           fits;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[DVD_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = (trial >= {1'b0, dvs_reg});
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.last_cnt;
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so the low bits suffice
            rem_next = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], fits};
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: rtl/pccc_norm.sv
// ============================================================================
// pccc_norm
// steps the estimate by halving or doubling until it is not above the target
// ============================================================================
`default_nettype none

module pccc_norm
    import pccc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire norm_req_t  req,
    input  wire logic [7:0] target,
    output norm_res_t       res
);

    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    logic [7:0] est_reg, est_next;
    logic [4:0] code_reg, code_next;

    logic [7:0] est_half;
    logic [9:0] est_x3;

    always_comb
    begin
        est_half  = {1'b0, est_reg[7:1]};
        busy_next = busy_reg;
        done_next = 1'b0;
        est_next  = est_reg;
        code_next = code_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            est_next  = req.est;
            code_next = START_CODE;
        end
        else if (busy_reg)
        begin
            if (est_reg > target)
            begin
                est_next  = est_half;
                code_next = code_reg - 1'b1;
                if (est_half <= target)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
            else if ({est_reg, 1'b0} > {1'b0, target})
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                est_next  = {est_reg[6:0], 1'b0};
                code_next = code_reg + 1'b1;
            end
        end
    end

    // three times the estimate; bits 8:1 are 1.5 times it, cut to 8 bits
    always_comb
    begin
        est_x3 = {2'b00, est_reg} + {1'b0, est_reg, 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        est_reg  <= est_next;
        code_reg <= code_next;
    end

    assign res.done = done_reg;
    assign res.code = code_reg;
    assign res.half = (est_x3[8:1] <= target);

endmodule

`default_nettype wire

FILE: rtl/pll_charge_pump_code_calc.sv
// ============================================================================
// pll_charge_pump_code_calc
// charge pump current code from horizontal period, gain and phase inputs
// ============================================================================
// One request at a time. One shared restoring divider first forms the line
// frequency 24576 / period. It then divides gain * 50737400 by that
// frequency, stopping at quotient bit 20. The normalizer then halves the
// estimate (at most 8 steps), or doubles it (at most 7 steps) and then
// stops on a final check. m_tvalid rises straight after acceptance for a
// zero period, after the first divider pass for a zero frequency, after
// the second pass for a zero estimate and otherwise once the normalizer
// is done. s_tready stays low from acceptance until the result is taken
// and returns high in the next cycle. Configuration writes are always
// ready and must only be issued while idle.
`default_nettype none

module pll_charge_pump_code_calc
    import pccc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    // request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [15:0] hsync_period, [23:16] gain_value, [24] phase_level_high,
    // [32:25] phase_correction, [39:33] zero
    input  wire logic [39:0] s_tdata,
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [4:0] current_code, [5] half_step, [7:6] status
    output logic [7:0]       m_tdata
);

    // configuration registers
    logic [7:0] fixed_corr_reg;
    logic [7:0] corr_total_reg;

    // request fields latched at acceptance
    logic [7:0] gain_reg;
    logic [7:0] target_reg;

    state_t state_reg, state_next;

    // result register
    logic [4:0] res_code_reg;
    logic       res_half_reg;
    status_t    res_status_reg;

    logic             s_accept;
    logic             m_accept;
    logic [15:0]      in_period;
    logic [7:0]       in_gain;
    logic             in_level;
    logic [7:0]       in_pcorr;
    logic [7:0]       in_target;

    div_req_t         div_req;
    logic [DVD_W-1:0] div_dividend;
    logic [DVS_W-1:0] div_divisor;
    logic             div_done;
    logic [DVD_W-1:0] div_quot;
    logic [DVD_W-1:0] product;
    logic [LINE_W-1:0] freq;
    logic [7:0]       est;

    norm_req_t        norm_req;
    norm_res_t        norm_res;

    logic             load_result;
    logic [4:0]       load_code;
    logic             load_half;
    status_t          load_status;

    assign in_period = s_tdata[15:0];
    assign in_gain   = s_tdata[23:16];
    assign in_level  = s_tdata[24];
    assign in_pcorr  = s_tdata[32:25];

    assign s_accept  = s_tvalid && s_tready;
    assign m_accept  = m_tvalid && m_tready;
    assign cfg_ready = 1'b1;

    // register writes, index beyond the list is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fixed_corr_reg <= '0;
            corr_total_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FIXED_CORR: fixed_corr_reg <= cfg_data;
                CFG_CORR_TOTAL: corr_total_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // target current: fixed value, else derived from the phase inputs
    always_comb
    begin
        if (fixed_corr_reg != '0)
            in_target = fixed_corr_reg;
        else if (in_level)
            in_target = corr_total_reg - in_pcorr;
        else
            in_target = {2'b00, in_pcorr[7:2]} + TARGET_OFFSET;
    end

    // full precision product, fed straight into the divider at its start
    assign product = DVD_W'(gain_reg) * DVD_W'(GAIN_CONST);
    assign freq    = div_quot[LINE_W-1:0];
    assign est     = div_quot[7:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                    state_next = (in_period == '0) ? S_OUT : S_DIV1;
            end
            S_DIV1:
            begin
                if (div_done)
                    state_next = (freq == '0) ? S_OUT : S_DIV2;
            end
            S_DIV2:
            begin
                if (div_done)
                    state_next = (est == '0) ? S_OUT : S_NORM;
            end
            S_NORM:
            begin
                if (norm_res.done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (m_accept)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_tready         = 1'b0;
        m_tvalid         = 1'b0;
        div_req.start    = 1'b0;
        div_req.last_cnt = DIV1_LAST_CNT;
        div_dividend     = {LINE_CONST, (DVD_W - LINE_W)'(0)};
        div_divisor      = in_period;
        norm_req.start   = 1'b0;
        norm_req.est     = est;
        load_result      = 1'b0;
        load_code        = START_CODE;
        load_half        = 1'b0;
        load_status      = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_accept)
                begin
                    if (in_period == '0)
                    begin
                        load_result = 1'b1;
                        load_status = ST_DIV_ZERO;
                    end
                    else
                        div_req.start = 1'b1;
                end
            end
            S_DIV1:
            begin
                // second pass: product over line frequency
                div_req.last_cnt = DIV2_LAST_CNT;
                div_dividend     = product;
                div_divisor      = {1'b0, freq};
                if (div_done)
                begin
                    if (freq == '0)
                    begin
                        load_result = 1'b1;
                        load_status = ST_DIV_ZERO;
                    end
                    else
                        div_req.start = 1'b1;
                end
            end
            S_DIV2:
            begin
                if (div_done)
                begin
                    if (est == '0)
                    begin
                        load_result = 1'b1;
                        load_status = ST_ZERO_EST;
                    end
                    else
                        norm_req.start = 1'b1;
                end
            end
            S_NORM:
            begin
                if (norm_res.done)
                begin
                    load_result = 1'b1;
                    load_code   = norm_res.code;
                    load_half   = norm_res.half;
                end
            end
            S_OUT:
            begin
                m_tvalid = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            gain_reg   <= in_gain;
            target_reg <= in_target;
        end
        if (load_result)
        begin
            res_code_reg   <= load_code;
            res_half_reg   <= load_half;
            res_status_reg <= load_status;
        end
    end

    pccc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    pccc_norm u_norm (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (norm_req),
        .target (target_reg),
        .res    (norm_res)
    );

    assign m_tdata = {res_status_reg, res_half_reg, res_code_reg};

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ============================================================================
// tb
// self-checking bench for the charge pump current code calculator
// ============================================================================
// A table of directed requests runs first. It covers zero and oversized
// periods, a zero estimate, a zero target, a wrapped target and the gain and
// correction extremes. Random requests follow under six register settings.
// Every accepted request without a typed result is run through a predictor
// in the bench. The result stream is compared field by field, in order,
// against the stored predictions. Both stream sides idle in random bursts,
// and the last stretch of the run has no idling.
`default_nettype none

module tb;
    import pccc_pkg::*;

    // request fields as they sit in s_tdata
    typedef struct packed {
        logic [7:0]  pcorr;
        logic        level;
        logic [7:0]  gain;
        logic [15:0] period;
    } pump_req_t;

    // result fields as they sit in m_tdata
    typedef struct packed {
        status_t    status;
        logic       half;
        logic [4:0] code;
    } pump_res_t;

    // one row of the directed table; typed rows carry their result
    typedef struct packed {
        pump_req_t req;
        logic      typed;
        pump_res_t res;
    } dir_row_t;

    localparam int N_SETTINGS    = 6;
    localparam int REQS_PER_SET  = 125;
    localparam int CALM_AFTER    = 680;   // random requests before idling stops
    localparam int DRAIN_CYCLES  = 60;    // longer than the worst request latency
    localparam int STALL_LIMIT   = 2000;  // cycles without any handshake

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = CFG_FIXED_CORR;
    logic [7:0]  cfg_data = 8'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = 40'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    // shadow copies of the two registers, reset values first
    logic [7:0] fixed_now = 8'd0;
    logic [7:0] total_now = 8'd0;

    pump_res_t  codes_due[$];
    dir_row_t   dir_rows[$];

    logic       calm = 1'b0;
    int         mismatches = 0;
    int         n_sent = 0;
    int         n_random = 0;
    int         n_ok = 0;
    int         n_div_zero = 0;
    int         n_zero_est = 0;
    int         n_half = 0;
    int         idle_cycles = 0;
    int         rx_hold = 0;

    pll_charge_pump_code_calc dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predicted code, half-step flag and status for one request
    function automatic pump_res_t calc_pump_code(input pump_req_t r, input logic [7:0] fixed,
                                                 input logic [7:0] total);
        pump_res_t   res;
        logic [15:0] freq;
        logic [63:0] quot;
        logic [7:0]  est;
        logic [7:0]  target;
        logic [9:0]  est_x3;
        logic        done;
        int          n;
        res.code   = START_CODE;
        res.half   = 1'b0;
        res.status = ST_OK;
        done       = 1'b0;
        freq = (r.period != 16'd0) ? 16'(LINE_CONST) / r.period : 16'd0;
        if (freq == 16'd0)
        begin
            res.status = ST_DIV_ZERO;
            return res;
        end
        // full precision product, only the estimate is cut to 8 bits
        quot = (64'(r.gain) * 64'(GAIN_CONST)) / 64'(freq);
        est  = quot[EST_SHIFT+7:EST_SHIFT];
        if (fixed != 8'd0)
            target = fixed;
        else if (r.level)
            target = total - r.pcorr;
        else
            target = (r.pcorr >> 2) + TARGET_OFFSET;
        if (est == 8'd0)
        begin
            res.status = ST_ZERO_EST;
            return res;
        end
        // halve down into the target, or double while the next step still fits
        for (n = 0; n < 16 && !done; n++)
        begin
            if (est > target)
            begin
                est      = est >> 1;
                res.code = res.code - 5'd1;
                if (est <= target)
                    done = 1'b1;
            end
            else if ({est, 1'b0} > {1'b0, target})
                done = 1'b1;
            else
            begin
                est      = est << 1;
                res.code = res.code + 5'd1;
            end
        end
        // one and a half times the estimate, wrapped to 8 bits
        est_x3   = 10'(est) * 10'd3;
        res.half = (8'(est_x3 >> 1) <= target);
        return res;
    endfunction

    // random request, mostly periods that give a usable frequency
    function automatic pump_req_t draw_request();
        pump_req_t r;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            r.period = 16'($urandom_range(1, 24576));
        else if (pick < 75)
            r.period = 16'($urandom_range(1, 600));
        else if (pick < 85)
            r.period = 16'($urandom_range(24000, 24576));
        else if (pick < 92)
            r.period = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(24577, 65535));
        else
            r.period = 16'($urandom_range(0, 65535));
        // small gains push the normalizer toward doubling
        r.gain  = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 8)) :
                                                8'($urandom_range(0, 255));
        r.level = 1'($urandom_range(0, 1));
        r.pcorr = ($urandom_range(0, 15) == 0) ? total_now : 8'($urandom_range(0, 255));
        return r;
    endfunction

    task automatic dir_row(input logic [15:0] period, input logic [7:0] gain,
                           input logic level, input logic [7:0] pcorr, input logic typed,
                           input logic [4:0] code, input logic half, input status_t status);
        dir_row_t row;
        row.req.period = period;
        row.req.gain   = gain;
        row.req.level  = level;
        row.req.pcorr  = pcorr;
        row.typed      = typed;
        row.res.code   = code;
        row.res.half   = half;
        row.res.status = status;
        dir_rows.push_back(row);
    endtask

    // one request on the slave side; the prediction is stored at acceptance
    task automatic issue_request(input pump_req_t r, input logic typed, input pump_res_t given);
        pump_res_t want;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, r};
        do @(posedge clk); while (!s_tready);
        want = typed ? given : calc_pump_code(r, fixed_now, total_now);
        codes_due.push_back(want);
        n_sent++;
    endtask

    // both registers back to back, valid held across the two writes
    task automatic write_regs(input logic [7:0] fixed, input logic [7:0] total);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_FIXED_CORR;
        cfg_data  <= fixed;
        do @(posedge clk); while (!cfg_ready);
        fixed_now = fixed;
        cfg_index <= CFG_CORR_TOTAL;
        cfg_data  <= total;
        do @(posedge clk); while (!cfg_ready);
        total_now = total;
        cfg_valid <= 1'b0;
    endtask

    // wait until every predicted result is back, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (codes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // result side: random stall bursts, none once calm
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (calm)
            m_tready <= 1'b1;
        else if (rx_hold != 0)
            rx_hold <= rx_hold - 1;
        else if ($urandom_range(0, 5) == 0)
        begin
            m_tready <= 1'b0;
            rx_hold  <= $urandom_range(0, 11);
        end
        else
            m_tready <= 1'b1;
    end

    // result check against the oldest prediction
    always @(posedge clk)
    begin : check_result
        pump_res_t want;
        pump_res_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = pump_res_t'(m_tdata);
            if (codes_due.size() == 0)
            begin
                $error("result with no request outstanding: %h", m_tdata);
                mismatches++;
            end
            else
            begin
                want = codes_due.pop_front();
                if (got.code !== want.code)
                begin
                    $error("current_code: expected %0d, got %0d", want.code, got.code);
                    mismatches++;
                end
                if (got.half !== want.half)
                begin
                    $error("half_step: expected %0d, got %0d", want.half, got.half);
                    mismatches++;
                end
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    mismatches++;
                end
            end
            case (got.status)
                ST_OK:       n_ok++;
                ST_DIV_ZERO: n_div_zero++;
                default:     n_zero_est++;
            endcase
            if (got.half)
                n_half++;
        end
    end

    // watchdog: any handshake restarts the count
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin : run
        logic [7:0] fixed_set[N_SETTINGS];
        logic [7:0] total_set[N_SETTINGS];
        pump_res_t  none;
        int         s;
        int         k;
        none = '0;

        // register settings: reset values, extremes, then random
        fixed_set[0] = 8'd0;   total_set[0] = 8'd0;
        fixed_set[1] = 8'd0;   total_set[1] = 8'd255;
        fixed_set[2] = 8'd255; total_set[2] = 8'd0;
        fixed_set[3] = 8'd1;   total_set[3] = 8'd128;
        fixed_set[4] = 8'd0;   total_set[4] = 8'($urandom_range(1, 254));
        fixed_set[5] = 8'($urandom_range(2, 254));
        total_set[5] = 8'($urandom_range(0, 255));

        // directed table, registers at reset values
        //      period     gain    lvl   pcorr   typed code   half  status
        dir_row(16'd0,     8'd0,   1'b0, 8'd0,   1'b1, 5'd14, 1'b0, ST_DIV_ZERO); // zero period
        dir_row(16'd0,     8'd255, 1'b1, 8'd255, 1'b1, 5'd14, 1'b0, ST_DIV_ZERO);
        dir_row(16'd65535, 8'd255, 1'b1, 8'd255, 1'b1, 5'd14, 1'b0, ST_DIV_ZERO); // period max
        dir_row(16'd32768, 8'd1,   1'b0, 8'd0,   1'b1, 5'd14, 1'b0, ST_DIV_ZERO);
        dir_row(16'd24577, 8'd128, 1'b0, 8'd0,   1'b1, 5'd14, 1'b0, ST_DIV_ZERO); // just past
        dir_row(16'd24576, 8'd0,   1'b0, 8'd0,   1'b1, 5'd14, 1'b0, ST_ZERO_EST); // gain zero
        dir_row(16'd1,     8'd1,   1'b0, 8'd0,   1'b1, 5'd14, 1'b0, ST_ZERO_EST); // freq max
        dir_row(16'd24576, 8'd255, 1'b0, 8'd0,   1'b0, 5'd0,  1'b0, ST_OK);
        dir_row(16'd24576, 8'd255, 1'b0, 8'd255, 1'b0, 5'd0,  1'b0, ST_OK);
        dir_row(16'd24576, 8'd255, 1'b1, 8'd0,   1'b0, 5'd0,  1'b0, ST_OK);       // zero target
        dir_row(16'd24576, 8'd1,   1'b1, 8'd5,   1'b0, 5'd0,  1'b0, ST_OK);       // wrapped target
        dir_row(16'd2,     8'd255, 1'b1, 8'd1,   1'b0, 5'd0,  1'b0, ST_OK);       // many doublings
        dir_row(16'd12288, 8'd200, 1'b1, 8'd255, 1'b0, 5'd0,  1'b0, ST_OK);
        dir_row(16'd1000,  8'd100, 1'b0, 8'd128, 1'b0, 5'd0,  1'b0, ST_OK);
        dir_row(16'd24576, 8'd22,  1'b0, 8'd0,   1'b0, 5'd0,  1'b0, ST_OK);
        dir_row(16'd4096,  8'haa,  1'b1, 8'h55,  1'b0, 5'd0,  1'b0, ST_OK);
        dir_row(16'd8192,  8'h55,  1'b0, 8'haa,  1'b0, 5'd0,  1'b0, ST_OK);
        dir_row(16'd5461,  8'd7,   1'b0, 8'd3,   1'b0, 5'd0,  1'b0, ST_OK);

        // reset held low at the start, then released
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < dir_rows.size(); k++)
            issue_request(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].res);

        for (s = 0; s < N_SETTINGS; s++)
        begin
            // registers change only with nothing in flight
            if (s != 0)
            begin
                drain();
                write_regs(fixed_set[s], total_set[s]);
            end
            for (k = 0; k < REQS_PER_SET; k++)
            begin
                if (n_random >= CALM_AFTER)
                    calm <= 1'b1;
                issue_request(draw_request(), 1'b0, none);
                n_random++;
            end
        end
        drain();

        $display("ran %0d requests (%0d directed) over %0d register settings",
                 n_sent, dir_rows.size(), N_SETTINGS);
        $display("results: %0d ok, %0d zero frequency, %0d zero estimate, %0d half step",
                 n_ok, n_div_zero, n_zero_est, n_half);
        if (mismatches == 0 && codes_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
